### src/gda_pkg.sv
// ---------------------------------------------------------------------------
// gda_pkg: shared types and constants for gregorian date arithmetic
// Field widths, status codes, calendar tables and reciprocal constants.
// ---------------------------------------------------------------------------
package gda_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFF_W    = 21;
    localparam int DIST_W   = 22;
    localparam int WDAY_W   = 3;
    localparam int DN_W     = 23;

    localparam int MAX_YEAR  = 9999;
    localparam int YEAR_BIAS = 400;

    // linear day numbers of the first and last representable dates
    localparam int SY_LO = YEAR_BIAS - 1;
    localparam int DN_LO = 365 * SY_LO + SY_LO / 4 - SY_LO / 100 + SY_LO / 400 + 306;
    localparam int SY_HI = MAX_YEAR + YEAR_BIAS;
    localparam int DN_HI = 365 * SY_HI + SY_HI / 4 - SY_HI / 100 + SY_HI / 400 + 275 + 30;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // day number + WDAY_BIAS is a multiple of 7 on 1900-01-01
    localparam int WDAY_BIAS = 2;

    // ceiling reciprocals, exact over the operand ranges used
    localparam int M_DIV100  = 41944;     // >> 22
    localparam int M_ERA     = 15051803;  // >> 41, divide by 146097
    localparam int M_DIV7    = 19173962;  // >> 27
    localparam int M_DIV1460 = 367720;    // >> 29
    localparam int M_DIV36K  = 470373;    // >> 34, divide by 36524
    localparam int M_DIV365  = 367720;    // >> 27
    localparam int M_YDIV100 = 656;       // >> 16
    localparam int M_DIV153  = 3427;      // >> 19

    localparam int DAYS_ERA  = 146097;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD_A = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic                a_ok;
        logic                b_ok;
        logic [DIST_W-1:0]   span;
        logic                after;
        logic                equal;
    } t_info;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        case (m)
            4'd1:    month_len = 5'd31;
            4'd2:    month_len = 5'd28;
            4'd3:    month_len = 5'd31;
            4'd4:    month_len = 5'd30;
            4'd5:    month_len = 5'd31;
            4'd6:    month_len = 5'd30;
            4'd7:    month_len = 5'd31;
            4'd8:    month_len = 5'd31;
            4'd9:    month_len = 5'd30;
            4'd10:   month_len = 5'd31;
            4'd11:   month_len = 5'd30;
            4'd12:   month_len = 5'd31;
            default: month_len = 5'd0;
        endcase
    endfunction

    // days from march 1 to the start of a calendar month
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        case (m)
            4'd1:    cum_days = 9'd306;
            4'd2:    cum_days = 9'd337;
            4'd3:    cum_days = 9'd0;
            4'd4:    cum_days = 9'd31;
            4'd5:    cum_days = 9'd61;
            4'd6:    cum_days = 9'd92;
            4'd7:    cum_days = 9'd122;
            4'd8:    cum_days = 9'd153;
            4'd9:    cum_days = 9'd184;
            4'd10:   cum_days = 9'd214;
            4'd11:   cum_days = 9'd245;
            4'd12:   cum_days = 9'd275;
            default: cum_days = 9'd0;
        endcase
    endfunction

    // same, indexed by month counted from march
    function automatic logic [8:0] mp_days(input logic [3:0] mp);
        case (mp)
            4'd0:    mp_days = 9'd0;
            4'd1:    mp_days = 9'd31;
            4'd2:    mp_days = 9'd61;
            4'd3:    mp_days = 9'd92;
            4'd4:    mp_days = 9'd122;
            4'd5:    mp_days = 9'd153;
            4'd6:    mp_days = 9'd184;
            4'd7:    mp_days = 9'd214;
            4'd8:    mp_days = 9'd245;
            4'd9:    mp_days = 9'd275;
            4'd10:   mp_days = 9'd306;
            4'd11:   mp_days = 9'd337;
            default: mp_days = 9'd0;
        endcase
    endfunction

endpackage

### src/gda_in_if.sv
// ---------------------------------------------------------------------------
// gda_in_if: request channel
// Two dates and a signed day offset with valid/ready handshake.
// ---------------------------------------------------------------------------
interface gda_in_if import gda_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [YEAR_W-1:0]         year_a;
    logic [MONTH_W-1:0]        month_a;
    logic [DAY_W-1:0]          day_a;
    logic signed [OFF_W-1:0]   day_offset;
    logic [YEAR_W-1:0]         year_b;
    logic [MONTH_W-1:0]        month_b;
    logic [DAY_W-1:0]          day_b;

    modport source (output valid, year_a, month_a, day_a, day_offset, year_b, month_b,
                    day_b, input ready);
    modport sink   (input valid, year_a, month_a, day_a, day_offset, year_b, month_b,
                    day_b, output ready);
endinterface

### src/gda_out_if.sv
// ---------------------------------------------------------------------------
// gda_out_if: result channel
// Shifted date, validity flags, distance, ordering and weekday.
// ---------------------------------------------------------------------------
interface gda_out_if import gda_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [YEAR_W-1:0]     shifted_year;
    logic [MONTH_W-1:0]    shifted_month;
    logic [DAY_W-1:0]      shifted_day;
    logic [1:0]            shift_status;
    logic                  a_valid;
    logic                  b_valid;
    logic [DIST_W-1:0]     days_between;
    logic                  a_after_b;
    logic                  a_equals_b;
    logic [WDAY_W-1:0]     weekday_a;

    modport source (output valid, shifted_year, shifted_month, shifted_day, shift_status,
                    a_valid, b_valid, days_between, a_after_b, a_equals_b, weekday_a,
                    input ready);
    modport sink   (input valid, shifted_year, shifted_month, shifted_day, shift_status,
                    a_valid, b_valid, days_between, a_after_b, a_equals_b, weekday_a,
                    output ready);
endinterface

### src/gregorian_date_arithmetic.sv
// ---------------------------------------------------------------------------
// gregorian_date_arithmetic: date shift, distance and weekday
// Ten-stage pipeline: dates to day numbers, offset and compare, then the
// shifted day number back to year, month and day by constant reciprocals.
// ---------------------------------------------------------------------------
//   channel  dir  contents
//   i_in     in   year/month/day of A and B, signed day offset
//   o_out    out  shifted date and status, validity, distance, order, weekday
//
// the result waits in the output register until the receiver takes it
// one transaction per cycle unless the output stalls; the stage multipliers set the cycle time
// the whole pipeline advances whenever the output register is empty or taken
// reset clears the stage valid bits only
module gregorian_date_arithmetic import gda_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gda_in_if.sink    i_in,
    gda_out_if.source o_out
);

    localparam int NSTG = 10;

    logic [NSTG-1:0] r_vld;
    logic            en;

    assign en         = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    // stage 1: biased years, divide by 100, year days, month offsets, date compare
    logic [YEAR_W-1:0]  in_y [2];
    logic [MONTH_W-1:0] in_m [2];
    logic [DAY_W-1:0]   in_d [2];

    logic [14:0]  n_s1_t    [2];
    logic [14:0]  n_s1_sy   [2];
    logic [7:0]   n_s1_qt   [2];
    logic [7:0]   n_s1_qs   [2];
    logic [DN_W-1:0] n_s1_s365 [2];
    logic [DN_W-1:0] n_s1_moff [2];
    logic [30:0]  p_qt [2];
    logic [30:0]  p_qs [2];
    logic         n_s1_after, n_s1_equal;

    logic [14:0]  r_s1_t    [2];
    logic [14:0]  r_s1_sy   [2];
    logic [7:0]   r_s1_qt   [2];
    logic [7:0]   r_s1_qs   [2];
    logic [DN_W-1:0] r_s1_s365 [2];
    logic [DN_W-1:0] r_s1_moff [2];
    logic [MONTH_W-1:0] r_s1_m [2];
    logic [DAY_W-1:0]   r_s1_d [2];
    logic signed [OFF_W-1:0] r_s1_off;
    logic         r_s1_after, r_s1_equal;

    assign in_y[0] = i_in.year_a;
    assign in_m[0] = i_in.month_a;
    assign in_d[0] = i_in.day_a;
    assign in_y[1] = i_in.year_b;
    assign in_m[1] = i_in.month_b;
    assign in_d[1] = i_in.day_b;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_s1_t[k]    = 15'(in_y[k]) + 15'(YEAR_BIAS);
            n_s1_sy[k]   = n_s1_t[k] - 15'(in_m[k] <= 4'd2);
            p_qt[k]      = 31'(n_s1_t[k]) * 31'(M_DIV100);
            p_qs[k]      = 31'(n_s1_sy[k]) * 31'(M_DIV100);
            n_s1_qt[k]   = p_qt[k][29:22];
            n_s1_qs[k]   = p_qs[k][29:22];
            n_s1_s365[k] = DN_W'(n_s1_sy[k]) * DN_W'(365);
            n_s1_moff[k] = DN_W'(cum_days(in_m[k])) + DN_W'(in_d[k]) - DN_W'(1);
        end
        n_s1_after = (i_in.year_a > i_in.year_b)
                  || (i_in.year_a == i_in.year_b && i_in.month_a > i_in.month_b)
                  || (i_in.year_a == i_in.year_b && i_in.month_a == i_in.month_b
                      && i_in.day_a > i_in.day_b);
        n_s1_equal = (i_in.year_a == i_in.year_b) && (i_in.month_a == i_in.month_b)
                  && (i_in.day_a == i_in.day_b);
    end

    // stage 2: leap test, validity, day number
    logic [14:0]     n_q100 [2];
    logic            n_leap [2];
    logic [DAY_W:0]  n_len  [2];
    logic            n_s2_ok [2];
    logic [DN_W-1:0] n_s2_dn [2];

    logic            r_s2_ok [2];
    logic [DN_W-1:0] r_s2_dn [2];
    logic signed [OFF_W-1:0] r_s2_off;
    logic            r_s2_after, r_s2_equal;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_q100[k] = 15'(r_s1_qt[k]) * 15'(100);
            n_leap[k] = (r_s1_t[k][1:0] == 2'd0 && n_q100[k] != r_s1_t[k])
                     || (n_q100[k] == r_s1_t[k] && r_s1_qt[k][1:0] == 2'd0);
            n_len[k]  = (DAY_W+1)'(month_len(r_s1_m[k]))
                      + (DAY_W+1)'(r_s1_m[k] == 4'd2 && n_leap[k]);
            n_s2_ok[k] = (r_s1_d[k] != '0) && ((DAY_W+1)'(r_s1_d[k]) <= n_len[k]);
            n_s2_dn[k] = r_s1_s365[k] + DN_W'(r_s1_sy[k] >> 2) - DN_W'(r_s1_qs[k])
                       + DN_W'(r_s1_qs[k] >> 2) + r_s1_moff[k];
        end
    end

    // stage 3: shift, range check, distance, status
    logic [DN_W-1:0]   n_na, n_nb, n_diff;
    logic signed [DN_W:0] n_ns;
    logic              n_inr;
    t_info             n_s3_info;

    logic [DN_W-1:0]   r_s3_ns;
    logic [DN_W-1:0]   r_s3_wx;
    t_info             r_s3_info;

    always_comb begin
        n_na  = r_s2_ok[0] ? r_s2_dn[0] : '0;
        n_nb  = r_s2_ok[1] ? r_s2_dn[1] : '0;
        n_ns  = $signed({1'b0, n_na}) + (DN_W+1)'(r_s2_off);
        n_inr = (n_ns >= $signed((DN_W+1)'(DN_LO))) && (n_ns <= $signed((DN_W+1)'(DN_HI)));
        n_diff = (n_na > n_nb) ? (n_na - n_nb) : (n_nb - n_na);
        n_s3_info.a_ok  = r_s2_ok[0];
        n_s3_info.b_ok  = r_s2_ok[1];
        n_s3_info.after = r_s2_after;
        n_s3_info.equal = r_s2_equal;
        if (!(r_s2_ok[0] && r_s2_ok[1])) begin
            n_s3_info.span = '0;
        end else if (n_diff > DN_W'(DIST_MAX)) begin
            n_s3_info.span = DIST_MAX;
        end else begin
            n_s3_info.span = DIST_W'(n_diff);
        end
        if (!r_s2_ok[0]) begin
            n_s3_info.status = ST_BAD_A;
        end else if (!n_inr) begin
            n_s3_info.status = ST_RANGE;
        end else begin
            n_s3_info.status = ST_OK;
        end
    end

    // stage 4: era and weekday quotients
    logic [46:0] p_era;
    logic [47:0] p_w7;
    logic [5:0]  r_s4_era;
    logic [20:0] r_s4_q7;
    logic [DN_W-1:0] r_s4_ns, r_s4_wx;
    t_info       r_s4_info;

    assign p_era = 47'(r_s3_ns) * 47'(M_ERA);
    assign p_w7  = 48'(r_s3_wx) * 48'(M_DIV7);

    // stage 5: day of era, weekday
    logic [DN_W-1:0] n_doe_full, n_wd_full;
    logic [17:0]     r_s5_doe;
    logic [5:0]      r_s5_era;
    logic [WDAY_W-1:0] r_s5_wd;
    t_info           r_s5_info;

    assign n_doe_full = r_s4_ns - DN_W'(r_s4_era) * DN_W'(DAYS_ERA);
    assign n_wd_full  = r_s4_wx - DN_W'(r_s4_q7) * DN_W'(7);

    // stage 6: century and leap corrections
    logic [36:0] p_c1, p_c2;
    logic [17:0] r_s6_doe;
    logic [6:0]  r_s6_c1;
    logic [2:0]  r_s6_c2;
    logic        r_s6_c3;
    logic [5:0]  r_s6_era;
    logic [WDAY_W-1:0] r_s6_wd;
    t_info       r_s6_info;

    assign p_c1 = 37'(r_s5_doe) * 37'(M_DIV1460);
    assign p_c2 = 37'(r_s5_doe) * 37'(M_DIV36K);

    // stage 7: year of era
    logic [17:0] n_num;
    logic [36:0] p_yoe;
    logic [17:0] r_s7_doe;
    logic [8:0]  r_s7_yoe;
    logic [5:0]  r_s7_era;
    logic [WDAY_W-1:0] r_s7_wd;
    t_info       r_s7_info;

    assign n_num = r_s6_doe - 18'(r_s6_c1) + 18'(r_s6_c2) - 18'(r_s6_c3);
    assign p_yoe = 37'(n_num) * 37'(M_DIV365);

    // stage 8: day of year
    logic [18:0] p_yq;
    logic [17:0] n_yday, n_doy_full;
    logic [8:0]  r_s8_doy;
    logic [8:0]  r_s8_yoe;
    logic [5:0]  r_s8_era;
    logic [WDAY_W-1:0] r_s8_wd;
    t_info       r_s8_info;

    assign p_yq   = 19'(r_s7_yoe) * 19'(M_YDIV100);
    assign n_yday = 18'(r_s7_yoe) * 18'(365) + 18'(r_s7_yoe >> 2) - 18'(p_yq[17:16]);
    assign n_doy_full = r_s7_doe - n_yday;

    // stage 9: month counted from march
    logic [10:0] n_x5;
    logic [22:0] p_mp;
    logic [3:0]  r_s9_mp;
    logic [8:0]  r_s9_doy;
    logic [8:0]  r_s9_yoe;
    logic [5:0]  r_s9_era;
    logic [WDAY_W-1:0] r_s9_wd;
    t_info       r_s9_info;

    assign n_x5 = 11'(r_s8_doy) * 11'(5) + 11'd2;
    assign p_mp = 23'(n_x5) * 23'(M_DIV153);

    // stage 10: calendar fields into the output register
    logic [3:0]  n_mm;
    logic [8:0]  n_dd;
    logic [15:0] n_yy;
    logic        n_ok;

    logic [YEAR_W-1:0]  r_o_year;
    logic [MONTH_W-1:0] r_o_month;
    logic [DAY_W-1:0]   r_o_day;
    logic [WDAY_W-1:0]  r_o_wd;
    t_info              r_o_info;

    always_comb begin
        n_mm = (r_s9_mp < 4'd10) ? (r_s9_mp + 4'd3) : (r_s9_mp - 4'd9);
        n_dd = r_s9_doy - mp_days(r_s9_mp) + 9'd1;
        n_yy = 16'(r_s9_era) * 16'(YEAR_BIAS) + 16'(r_s9_yoe) + 16'(n_mm <= 4'd2)
             - 16'(YEAR_BIAS);
        n_ok = (r_s9_info.status == ST_OK);
    end

    // payload registers, all stages move together
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                r_s1_t[k]    <= n_s1_t[k];
                r_s1_sy[k]   <= n_s1_sy[k];
                r_s1_qt[k]   <= n_s1_qt[k];
                r_s1_qs[k]   <= n_s1_qs[k];
                r_s1_s365[k] <= n_s1_s365[k];
                r_s1_moff[k] <= n_s1_moff[k];
                r_s1_m[k]    <= in_m[k];
                r_s1_d[k]    <= in_d[k];
                r_s2_ok[k]   <= n_s2_ok[k];
                r_s2_dn[k]   <= n_s2_dn[k];
            end
            r_s1_off   <= i_in.day_offset;
            r_s1_after <= n_s1_after;
            r_s1_equal <= n_s1_equal;

            r_s2_off   <= r_s1_off;
            r_s2_after <= r_s1_after;
            r_s2_equal <= r_s1_equal;

            r_s3_ns   <= DN_W'(n_ns);
            r_s3_wx   <= n_na + DN_W'(WDAY_BIAS);
            r_s3_info <= n_s3_info;

            r_s4_era  <= p_era[46:41];
            r_s4_q7   <= p_w7[47:27];
            r_s4_ns   <= r_s3_ns;
            r_s4_wx   <= r_s3_wx;
            r_s4_info <= r_s3_info;

            r_s5_doe  <= 18'(n_doe_full);
            r_s5_era  <= r_s4_era;
            r_s5_wd   <= r_s4_info.a_ok ? WDAY_W'(n_wd_full) : '0;
            r_s5_info <= r_s4_info;

            r_s6_doe  <= r_s5_doe;
            r_s6_c1   <= p_c1[35:29];
            r_s6_c2   <= p_c2[36:34];
            r_s6_c3   <= (r_s5_doe == 18'(DAYS_ERA - 1));
            r_s6_era  <= r_s5_era;
            r_s6_wd   <= r_s5_wd;
            r_s6_info <= r_s5_info;

            r_s7_doe  <= r_s6_doe;
            r_s7_yoe  <= p_yoe[35:27];
            r_s7_era  <= r_s6_era;
            r_s7_wd   <= r_s6_wd;
            r_s7_info <= r_s6_info;

            r_s8_doy  <= 9'(n_doy_full);
            r_s8_yoe  <= r_s7_yoe;
            r_s8_era  <= r_s7_era;
            r_s8_wd   <= r_s7_wd;
            r_s8_info <= r_s7_info;

            r_s9_mp   <= p_mp[22:19];
            r_s9_doy  <= r_s8_doy;
            r_s9_yoe  <= r_s8_yoe;
            r_s9_era  <= r_s8_era;
            r_s9_wd   <= r_s8_wd;
            r_s9_info <= r_s8_info;

            r_o_year  <= n_ok ? YEAR_W'(n_yy) : '0;
            r_o_month <= n_ok ? n_mm : '0;
            r_o_day   <= n_ok ? DAY_W'(n_dd) : '0;
            r_o_wd    <= r_s9_wd;
            r_o_info  <= r_s9_info;
        end
    end

    assign o_out.valid         = r_vld[NSTG-1];
    assign o_out.shifted_year  = r_o_year;
    assign o_out.shifted_month = r_o_month;
    assign o_out.shifted_day   = r_o_day;
    assign o_out.shift_status  = r_o_info.status;
    assign o_out.a_valid       = r_o_info.a_ok;
    assign o_out.b_valid       = r_o_info.b_ok;
    assign o_out.days_between  = r_o_info.span;
    assign o_out.a_after_b     = r_o_info.after;
    assign o_out.a_equals_b    = r_o_info.equal;
    assign o_out.weekday_a     = r_o_wd;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_ok_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.shift_status == ST_OK) |->
        (o_out.shifted_month >= 4'd1 && o_out.shifted_month <= 4'd12
         && o_out.shifted_day >= 5'd1 && o_out.shifted_year <= YEAR_W'(MAX_YEAR)))
        else $error("shifted date out of calendar range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.shift_status != ST_OK) |->
        (o_out.shifted_year == '0 && o_out.shifted_month == '0 && o_out.shifted_day == '0))
        else $error("shifted date not cleared on error");

    a_bad_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.a_valid) |->
        (o_out.shift_status == ST_BAD_A && o_out.weekday_a == '0
         && o_out.days_between == '0))
        else $error("invalid date A not reported");

    a_equal_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.a_equals_b) |-> (o_out.days_between == '0))
        else $error("equal dates with nonzero distance");
`endif

endmodule

### tb/gda_tb_if.sv
// ---------------------------------------------------------------------------
// gda_tb_pkg: testbench-side transaction types
// The block's channel interfaces are reused from the source tree; this file
// holds the testbench's own transaction record type.
// ---------------------------------------------------------------------------
package gda_tb_pkg;
    import gda_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        t_status              status;
        logic                 a_ok;
        logic                 b_ok;
        logic [DIST_W-1:0]    span;
        logic                 after;
        logic                 equal;
        logic [WDAY_W-1:0]    wday;
    } t_date_result;
endpackage

### tb/gda_checker.sv
// ---------------------------------------------------------------------------
// gda_checker: date arithmetic scoreboard
// Watches both channels, computes the expected shifted date, distance,
// ordering and weekday for each request and compares in order.
// ---------------------------------------------------------------------------
module gda_checker import gda_pkg::*; import gda_tb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gda_in_if       i_in,
    gda_out_if      i_out,
    output int      o_errors,
    output int      o_pending,
    output int      o_results,
    output int      o_range_hits,
    output int      o_bad_a_hits
);

    t_date_result pending_dates[$];

    function automatic bit is_leap(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic bit date_real(longint y, longint m, longint d);
        longint len;
        if (m < 1 || m > 12 || d < 1 || d > 31) return 0;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = is_leap(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return d <= len;
    endfunction

    // march-based linear day count, year biased by 400
    function automatic longint day_count(longint y, longint m, longint d);
        longint sy, mp;
        sy = y + 400 - ((m <= 2) ? 1 : 0);
        mp = (m + 9) % 12;
        return 365 * sy + sy / 4 - sy / 100 + sy / 400 + (153 * mp + 2) / 5 + d - 1;
    endfunction

    function automatic t_date_result date_math(
        longint ya, longint ma, longint da, longint off,
        longint yb, longint mb, longint db);
        t_date_result r;
        longint na, nb, ns, era, doe, yoe, doy, mp, mm, w, diff;
        bit va, vb;
        r = '0;
        va = date_real(ya, ma, da);
        vb = date_real(yb, mb, db);
        na = va ? day_count(ya, ma, da) : 0;
        nb = vb ? day_count(yb, mb, db) : 0;
        r.a_ok = va;
        r.b_ok = vb;
        if (!va) begin
            r.status = ST_BAD_A;
        end else begin
            ns = na + off;
            if (ns < day_count(0, 1, 1) || ns > day_count(MAX_YEAR, 12, 31)) begin
                r.status = ST_RANGE;
            end else begin
                era = ns / 146097;
                doe = ns - era * 146097;
                yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
                doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
                mp = (5 * doy + 2) / 153;
                mm = (mp < 10) ? mp + 3 : mp - 9;
                r.day = doy - (153 * mp + 2) / 5 + 1;
                r.month = mm;
                r.year = era * 400 + yoe + ((mm <= 2) ? 1 : 0) - 400;
                r.status = ST_OK;
            end
            w = (na - day_count(1900, 1, 1)) % 7;
            if (w < 0) w += 7;
            r.wday = w;
        end
        if (va && vb) begin
            diff = (na > nb) ? na - nb : nb - na;
            r.span = (diff > 4194303) ? 4194303 : diff;
        end
        r.after = (ya > yb) || (ya == yb && ma > mb) || (ya == yb && ma == mb && da > db);
        r.equal = (ya == yb) && (ma == mb) && (da == db);
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
        o_range_hits = 0;
        o_bad_a_hits = 0;
    end

    always @(posedge i_clk) begin
        t_date_result e;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            e = date_math(i_in.year_a, i_in.month_a, i_in.day_a, longint'(i_in.day_offset),
                          i_in.year_b, i_in.month_b, i_in.day_b);
            if (e.status == ST_RANGE) o_range_hits++;
            if (e.status == ST_BAD_A) o_bad_a_hits++;
            pending_dates.push_back(e);
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            o_results++;
            if (pending_dates.size() == 0) begin
                report("unexpected transaction", 1, 0);
            end else begin
                e = pending_dates.pop_front();
                if (i_out.shifted_year !== e.year)   report("shifted_year", i_out.shifted_year, e.year);
                if (i_out.shifted_month !== e.month) report("shifted_month", i_out.shifted_month, e.month);
                if (i_out.shifted_day !== e.day)     report("shifted_day", i_out.shifted_day, e.day);
                if (i_out.shift_status !== e.status) report("shift_status", i_out.shift_status, e.status);
                if (i_out.a_valid !== e.a_ok)        report("a_valid", i_out.a_valid, e.a_ok);
                if (i_out.b_valid !== e.b_ok)        report("b_valid", i_out.b_valid, e.b_ok);
                if (i_out.days_between !== e.span)   report("days_between", i_out.days_between, e.span);
                if (i_out.a_after_b !== e.after)     report("a_after_b", i_out.a_after_b, e.after);
                if (i_out.a_equals_b !== e.equal)    report("a_equals_b", i_out.a_equals_b, e.equal);
                if (i_out.weekday_a !== e.wday)      report("weekday_a", i_out.weekday_a, e.wday);
            end
        end
        o_pending = pending_dates.size();
    end

endmodule

### tb/gregorian_date_arithmetic_tb.sv
// ---------------------------------------------------------------------------
// gregorian_date_arithmetic_tb: top of the date arithmetic testbench
// Drives directed calendar corner cases then mostly valid random dates with
// bursty input and a stalling output; a checker module scores the results.
// ---------------------------------------------------------------------------
module gregorian_date_arithmetic_tb;
    import gda_pkg::*;

    localparam int N_RANDOM  = 1000;
    localparam int LIMIT     = 200000;
    localparam int LATENCY   = 10;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending, results, range_hits, bad_a_hits;
    int   cycles = 0;
    int   sent = 0;
    bit   long_hold = 0;
    bit   stim_done = 0;

    gda_in_if  req_ch ();
    gda_out_if res_ch ();

    gregorian_date_arithmetic dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source)
    );

    gda_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (req_ch),
        .i_out        (res_ch),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_range_hits (range_hits),
        .o_bad_a_hits (bad_a_hits)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: own stall pattern, plus one long hold-off while requests keep coming
    initial begin
        int hold;
        res_ch.ready = 0;
        @(negedge i_clk);
        while (1) begin
            if (long_hold) begin
                res_ch.ready <= 0;
                for (hold = 0; hold < 60; hold++) @(negedge i_clk);
                long_hold = 0;
            end else if (stim_done || $urandom_range(0, 3) != 0) begin
                res_ch.ready <= 1;
            end else begin
                res_ch.ready <= 0;
            end
            @(negedge i_clk);
        end
    end

    task automatic send(input logic [YEAR_W-1:0] ya, input logic [MONTH_W-1:0] ma,
                        input logic [DAY_W-1:0] da, input logic signed [OFF_W-1:0] off,
                        input logic [YEAR_W-1:0] yb, input logic [MONTH_W-1:0] mb,
                        input logic [DAY_W-1:0] db);
        req_ch.valid      <= 1;
        req_ch.year_a     <= ya;
        req_ch.month_a    <= ma;
        req_ch.day_a      <= da;
        req_ch.day_offset <= off;
        req_ch.year_b     <= yb;
        req_ch.month_b    <= mb;
        req_ch.day_b      <= db;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic pause(input int n);
        req_ch.valid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [DAY_W-1:0] random_day(input logic [YEAR_W-1:0] y,
                                                     input logic [MONTH_W-1:0] m);
        int len;
        len = month_len(m);
        if (m == 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)) len++;
        // lean toward month ends
        return ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
    endfunction

    function automatic logic signed [OFF_W-1:0] random_offset();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 2097151);
            1:       return $signed(21'($urandom_range(0, 800))) - 400;
            2:       return $signed(21'($urandom_range(0, 80000))) - 40000;
            default: return $signed(21'($urandom_range(0, 2000000))) - 1000000;
        endcase
    endfunction

    initial begin
        int i, burst;
        logic [YEAR_W-1:0] ya, yb;
        logic [MONTH_W-1:0] ma, mb;
        logic [DAY_W-1:0] da, db;
        req_ch.valid = 0;
        req_ch.year_a = 0; req_ch.month_a = 0; req_ch.day_a = 0;
        req_ch.day_offset = 0;
        req_ch.year_b = 0; req_ch.month_b = 0; req_ch.day_b = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed corners
        send(1900, 1, 1, 0, 1900, 1, 1);
        send(0, 1, 1, -1, 0, 1, 1);
        send(0, 1, 1, 0, 9999, 12, 31);
        send(9999, 12, 31, 1, 0, 1, 1);
        send(9999, 12, 31, 0, 9999, 12, 30);
        send(2000, 2, 29, 365, 1999, 2, 28);
        send(1900, 2, 29, 1, 1900, 2, 28);
        send(2100, 2, 29, 0, 2004, 2, 29);
        send(2023, 13, 5, 10, 2023, 12, 5);
        send(2023, 15, 31, 1, 2023, 0, 0);
        send(2023, 4, 31, 1, 2023, 4, 30);
        send(2023, 6, 0, 5, 2023, 6, 1);
        send(16383, 15, 31, -1048576, 16383, 15, 31);
        send(10000, 1, 1, 0, 1, 1, 1);
        send(1899, 12, 31, -1048576, 1900, 1, 1);
        send(5000, 6, 15, 1048575, 5000, 6, 15);
        send(1600, 3, 1, -1, 1700, 3, 1);
        send(1, 1, 1, 21'sd1048575, 9998, 12, 31);
        send(2024, 12, 31, 1, 2025, 1, 1);
        send(1752, 9, 14, -11, 1066, 10, 14);

        // a burst during which the receiver holds off
        long_hold = 1;
        for (i = 0; i < 40; i++)
            send($urandom_range(0, 9999), $urandom_range(1, 12), $urandom_range(1, 28),
                 random_offset(), $urandom_range(0, 9999), $urandom_range(1, 12), 1);

        i = 0;
        while (i < N_RANDOM) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            while (burst > 0 && i < N_RANDOM) begin
                if ($urandom_range(0, 9) == 0) begin
                    // raw fields, mostly invalid
                    send($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                         $urandom_range(0, 2097151), $urandom_range(0, 16383),
                         $urandom_range(0, 15), $urandom_range(0, 31));
                end else begin
                    ya = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                                      : $urandom_range(0, 9999);
                    ma = $urandom_range(1, 12);
                    da = random_day(ya, ma);
                    yb = ($urandom_range(0, 2) == 0) ? ya : $urandom_range(0, 9999);
                    mb = ($urandom_range(0, 2) == 0) ? ma : $urandom_range(1, 12);
                    db = ($urandom_range(0, 3) == 0) ? da : random_day(yb, mb);
                    send(ya, ma, da, random_offset(), yb, mb, db);
                end
                i++;
                burst--;
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
        end
        req_ch.valid <= 0;
        stim_done = 1;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        $display("sent %0d requests, checked %0d results", sent, results);
        $display("shifts out of range: %0d, invalid first dates: %0d", range_hits, bad_a_hits);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
src/gda_pkg.sv
src/gda_in_if.sv
src/gda_out_if.sv
src/gregorian_date_arithmetic.sv
tb/gda_tb_if.sv
tb/gda_checker.sv
tb/gregorian_date_arithmetic_tb.sv
